// ===== hdl/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Command codes, error codes, widths and the sequencer state type.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int MOD_WIDTH = 31;
  localparam int CMD_WIDTH = 3;
  localparam int EXP_WIDTH = 63;
  localparam int ERR_WIDTH = 2;
  localparam logic [MOD_WIDTH-1:0] MOD_RESET = 31'd1000000007;

  localparam logic [CMD_WIDTH-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_POW = 3'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_INV = 3'd5;

  localparam logic [ERR_WIDTH-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_WIDTH-1:0] ERR_NOINV = 2'd1;
  localparam logic [ERR_WIDTH-1:0] ERR_RANGE = 2'd2;

  // Bit counter width for one serial multiply or divide pass.
  localparam int CNT_WIDTH = $clog2(MOD_WIDTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INV,
    ST_INV_FIX,
    ST_DIV_MUL,
    ST_POW_BIT,
    ST_POW_SQR,
    ST_MUL_WAIT,
    ST_DONE
  } mau_state_t;

endpackage

// ===== hdl/mau_if.sv =====
// ----------------------------------------------------------------------------
// mau_in_if / mau_out_if: valid-ready channels of the modular arithmetic unit
// Each carries one word per handshake.
// ----------------------------------------------------------------------------
interface mau_in_if import mau_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_WIDTH-1:0] cmd;
  logic [MOD_WIDTH-1:0] operand_a;
  logic [MOD_WIDTH-1:0] operand_b;
  logic [EXP_WIDTH-1:0] exponent;
  modport source (output valid, cmd, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, exponent, output ready);
endinterface

interface mau_out_if import mau_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] result;
  logic [ERR_WIDTH-1:0] error;
  modport source (output valid, result, error, input ready);
  modport sink   (input valid, result, error, output ready);
endinterface

// ===== hdl/mau_mulmod.sv =====
// ----------------------------------------------------------------------------
// mau_mulmod: bit-serial modular multiplier
// Scans the multiplier from its top bit, one bit per cycle, doubling and
// adding with a conditional subtract of the modulus each time.
// ----------------------------------------------------------------------------
module mau_mulmod import mau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] x,
  input  logic [MOD_WIDTH-1:0] y,
  input  logic [MOD_WIDTH-1:0] m,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] p
);

  logic                 busy;
  logic [CNT_WIDTH-1:0] cnt;
  logic [MOD_WIDTH-1:0] xr;
  logic [MOD_WIDTH-1:0] yr;
  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH-1:0] p_next;

  // Both operands are below m, so each step needs one subtract per add.
  always_comb begin
    dbl     = {p, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = dbl_red + (yr[MOD_WIDTH-1] ? {1'b0, xr} : '0);
    p_next  = (sum >= {1'b0, m}) ? MOD_WIDTH'(sum - {1'b0, m}) : sum[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(MOD_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x;
      yr <= y;
      p  <= '0;
    end else if (busy) begin
      p  <= p_next;
      yr <= {yr[MOD_WIDTH-2:0], 1'b0};
    end
  end

endmodule

// ===== hdl/mau_ctrl.sv =====
// ----------------------------------------------------------------------------
// mau_ctrl: command sequencer of the modular arithmetic unit
// Checks operands, runs the extended Euclid inverse with a bit-serial divider,
// and drives the serial multiplier for mul, div and pow.
// ----------------------------------------------------------------------------
module mau_invmod import mau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] x,
  input  logic [MOD_WIDTH-1:0] m,
  output logic                 done,
  output logic                 ok,
  output logic [MOD_WIDTH-1:0] inv
);

  logic                 busy;
  logic [CNT_WIDTH-1:0] cnt;
  logic [MOD_WIDTH-1:0] mr;
  logic [MOD_WIDTH-1:0] r0, r1;
  logic [MOD_WIDTH-1:0] s0, s1;
  logic [MOD_WIDTH-1:0] dvd;
  logic [MOD_WIDTH-1:0] rem;
  logic [MOD_WIDTH-1:0] tacc;
  logic [MOD_WIDTH:0]   rem_sh, rem_sub;
  logic                 qbit;
  logic [MOD_WIDTH-1:0] rem_next;
  logic [MOD_WIDTH:0]   dbl, dbl_red, sum;
  logic [MOD_WIDTH-1:0] tacc_next;
  logic [MOD_WIDTH-1:0] s_next;

  // Restoring division of r0 by r1, one quotient bit per cycle. The quotient
  // bits feed a Horner accumulation of q * s1 modulo m as they appear.
  always_comb begin
    rem_sh    = {rem, dvd[MOD_WIDTH-1]};
    rem_sub   = rem_sh - {1'b0, r1};
    qbit      = (rem_sh >= {1'b0, r1});
    rem_next  = qbit ? rem_sub[MOD_WIDTH-1:0] : rem_sh[MOD_WIDTH-1:0];
    dbl       = {tacc, 1'b0};
    dbl_red   = (dbl >= {1'b0, mr}) ? dbl - {1'b0, mr} : dbl;
    sum       = dbl_red + (qbit ? {1'b0, s1} : '0);
    tacc_next = (sum >= {1'b0, mr}) ? MOD_WIDTH'(sum - {1'b0, mr}) : sum[MOD_WIDTH-1:0];
    s_next    = (s0 >= tacc) ? s0 - tacc : s0 + (mr - tacc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == '0) begin
          if (r1 == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= CNT_WIDTH'(MOD_WIDTH);
          end
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // The coefficient pair lags one step: at each check cycle the true pair is
  // (s1, s0 - q * s1), so s1 starts at one and s0 at zero.
  always_ff @(posedge clk) begin
    if (start) begin
      mr   <= m;
      r0   <= x;
      r1   <= m;
      s0   <= '0;
      s1   <= MOD_WIDTH'(1);
      tacc <= '0;
    end else if (busy) begin
      if (cnt == '0) begin
        s0 <= s1;
        s1 <= s_next;
        if (r1 == '0) begin
          ok  <= (r0 == MOD_WIDTH'(1));
          inv <= s1;
        end else begin
          dvd  <= r0;
          rem  <= '0;
          tacc <= '0;
        end
      end else begin
        rem  <= rem_next;
        dvd  <= {dvd[MOD_WIDTH-2:0], 1'b0};
        tacc <= tacc_next;
        if (cnt == CNT_WIDTH'(1)) begin
          r0 <= r1;
          r1 <= rem_next;
        end
      end
    end
  end

endmodule

module mau_ctrl import mau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [MOD_WIDTH-1:0] modulus,
  mau_in_if.sink               in_ch,
  mau_out_if.source            out_ch
);

  mau_state_t state, state_next;

  logic [CMD_WIDTH-1:0] cmd;
  logic [MOD_WIDTH-1:0] a;
  logic [MOD_WIDTH-1:0] b;
  logic [EXP_WIDTH-1:0] e;
  logic [MOD_WIDTH-1:0] m;
  logic [MOD_WIDTH-1:0] acc;

  logic                 mul_start;
  logic [MOD_WIDTH-1:0] mul_x, mul_y;
  logic                 mul_done;
  logic [MOD_WIDTH-1:0] mul_p;

  logic                 inv_start;
  logic [MOD_WIDTH-1:0] inv_x;
  logic                 inv_done;
  logic                 inv_ok;
  logic [MOD_WIDTH-1:0] inv_val;

  logic                 pending_sqr;
  logic                 accept;
  logic                 range_bad;
  logic                 uses_b;
  logic [MOD_WIDTH:0]   addr, subr;

  assign accept = in_ch.valid && in_ch.ready;
  assign uses_b = (in_ch.cmd == CMD_ADD) || (in_ch.cmd == CMD_SUB) ||
                  (in_ch.cmd == CMD_MUL) || (in_ch.cmd == CMD_DIV);
  assign range_bad = (modulus < MOD_WIDTH'(2)) || (in_ch.operand_a >= modulus) ||
                     (uses_b && (in_ch.operand_b >= modulus));
  assign addr = {1'b0, in_ch.operand_a} + {1'b0, in_ch.operand_b};
  assign subr = {1'b0, in_ch.operand_a} + {1'b0, modulus - in_ch.operand_b};

  assign inv_start = accept && !range_bad &&
                     ((in_ch.cmd == CMD_DIV) || (in_ch.cmd == CMD_INV));
  assign inv_x     = (in_ch.cmd == CMD_DIV) ? in_ch.operand_b : in_ch.operand_a;

  mau_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (m),
    .done  (mul_done),
    .p     (mul_p)
  );

  mau_invmod u_inv (
    .clk   (clk),
    .rst   (rst),
    .start (inv_start),
    .x     (inv_x),
    .m     (modulus),
    .done  (inv_done),
    .ok    (inv_ok),
    .inv   (inv_val)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.cmd > CMD_INV || range_bad) state_next = ST_DONE;
          else begin
            case (in_ch.cmd)
              CMD_ADD, CMD_SUB: state_next = ST_DONE;
              CMD_MUL:          state_next = ST_MUL_WAIT;
              CMD_POW:          state_next = ST_POW_BIT;
              default:          state_next = ST_INV;
            endcase
          end
        end
      end
      ST_INV:      if (inv_done) state_next = ST_INV_FIX;
      ST_INV_FIX: begin
        if (!inv_ok || cmd == CMD_INV) state_next = ST_DONE;
        else state_next = ST_DIV_MUL;
      end
      ST_DIV_MUL:  state_next = ST_MUL_WAIT;
      ST_POW_BIT: begin
        if (e == '0) state_next = ST_DONE;
        else state_next = ST_MUL_WAIT;
      end
      ST_POW_SQR:  state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (cmd != CMD_POW) state_next = ST_DONE;
          else if (pending_sqr) state_next = ST_POW_SQR;
          else state_next = ST_POW_BIT;
        end
      end
      ST_DONE:     if (out_ch.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state == ST_IDLE);
    out_ch.valid = (state == ST_DONE);
    out_ch.result = acc;
  end

  // Multiplier launch: mul starts on the accepted word itself; div launches
  // from its multiply state, and pow from its bit and square states.
  always_comb begin
    mul_start = 1'b0;
    mul_x     = a;
    mul_y     = b;
    unique case (state)
      ST_IDLE: begin
        mul_start = accept && !range_bad && (in_ch.cmd == CMD_MUL);
        mul_x     = in_ch.operand_a;
        mul_y     = in_ch.operand_b;
      end
      ST_DIV_MUL: begin
        mul_start = 1'b1;
        mul_x     = a;
        mul_y     = acc;
      end
      ST_POW_BIT: begin
        mul_start = (e != '0);
        if (e[0]) begin
          mul_x = acc;
          mul_y = a;
        end else begin
          mul_x = a;
          mul_y = a;
        end
      end
      ST_POW_SQR: begin
        mul_start = 1'b1;
        mul_x     = a;
        mul_y     = a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.error <= ERR_OK;
      pending_sqr  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) begin
          cmd <= in_ch.cmd;
          m   <= modulus;
          e   <= in_ch.exponent;
          out_ch.error <= ERR_OK;
          acc <= '0;
          if (in_ch.cmd > CMD_INV) begin
            acc <= '0;
          end else if (range_bad) begin
            out_ch.error <= ERR_RANGE;
          end else begin
            case (in_ch.cmd)
              CMD_ADD: acc <= (addr >= {1'b0, modulus}) ?
                              MOD_WIDTH'(addr - {1'b0, modulus}) : addr[MOD_WIDTH-1:0];
              CMD_SUB: acc <= (subr >= {1'b0, modulus}) ?
                              MOD_WIDTH'(subr - {1'b0, modulus}) : subr[MOD_WIDTH-1:0];
              CMD_POW: acc <= MOD_WIDTH'(1);
              default: ;
            endcase
            a <= in_ch.operand_a;
            b <= in_ch.operand_b;
          end
        end
        ST_INV_FIX: begin
          if (!inv_ok) begin
            out_ch.error <= ERR_NOINV;
            acc <= '0;
          end else begin
            acc <= inv_val;
          end
        end
        ST_POW_BIT: if (e != '0) begin
          pending_sqr <= e[0];
          if (!e[0]) e <= e >> 1;
        end
        ST_POW_SQR: begin
          pending_sqr <= 1'b0;
          e <= e >> 1;
        end
        ST_MUL_WAIT: if (mul_done) begin
          if (cmd != CMD_POW) acc <= mul_p;
          else if (pending_sqr) acc <= mul_p;
          else a <= mul_p;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/modular_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// modular_arithmetic_unit: add, sub, mul, div, pow and inverse modulo m
// Top level; holds the modulus register and the command sequencer.
// ----------------------------------------------------------------------------
//   port       dir    word
//   in_ch      sink   cmd, operand_a, operand_b, exponent
//   out_ch     source result, error
//   cfg_we/wd  in     modulus
//
// One word at a time. Add and sub results are computed in the accepting
// state; mul runs the serial multiplier once. The inverse runs one serial
// Euclid division per step; div adds one multiply after it. Pow runs a square
// per exponent bit and one more multiply for each set bit.
// The result word holds until taken; the next word is taken after it leaves.
// Reset loads the modulus 1000000007 and idles the sequencer.
module modular_arithmetic_unit import mau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [MOD_WIDTH-1:0] cfg_wd,
  mau_in_if.sink               in_ch,
  mau_out_if.source            out_ch
);

  logic [MOD_WIDTH-1:0] modulus;

  always_ff @(posedge clk) begin
    if (rst)         modulus <= MOD_RESET;
    else if (cfg_we) modulus <= cfg_wd;
  end

  mau_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/modular_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_tb: self-checking bench of the modular arithmetic unit
// Drives command words under random source gaps and sink stalls, predicts
// each result word in the bench, and compares result and error field by field
// across several modulus settings, small, composite, degenerate and maximal.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_tb;
  import mau_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;

  typedef struct {
    logic [MOD_WIDTH-1:0] result;
    logic [ERR_WIDTH-1:0] error;
  } residue_word_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [MOD_WIDTH-1:0] cfg_wd;

  mau_in_if  in_ch ();
  mau_out_if out_ch ();

  modular_arithmetic_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_we),
    .cfg_wd (cfg_wd),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  residue_word_t        pending_residues[$];
  logic [MOD_WIDTH-1:0] shadow_modulus;
  int unsigned          mismatches;
  int unsigned          cycle_count;
  int unsigned          words_sent;
  int unsigned          words_checked;
  int unsigned          cmd_tally[8];
  int unsigned          sink_stall;
  bit                   calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Extended Euclid on the residue; ok is cleared when gcd is not one.
  function automatic logic [MOD_WIDTH-1:0] inverse_of(input logic [MOD_WIDTH-1:0] x,
                                                       input logic [MOD_WIDTH-1:0] m,
                                                       output bit ok);
    longint r0, r1, s0, s1, q, t;
    r0 = x;
    r1 = m;
    s0 = 1;
    s1 = 0;
    while (r1 != 0) begin
      q  = r0 / r1;
      t  = r0 - q * r1;
      r0 = r1;
      r1 = t;
      t  = s0 - q * s1;
      s0 = s1;
      s1 = t;
    end
    ok = (r0 == 1);
    if (s0 < 0) s0 += longint'(m);
    return ok ? MOD_WIDTH'(longint'(s0) % longint'(m)) : '0;
  endfunction

  function automatic logic [MOD_WIDTH-1:0] mulmod(input logic [63:0] x,
                                                  input logic [63:0] y,
                                                  input logic [63:0] m);
    return MOD_WIDTH'((x * y) % m);
  endfunction

  function automatic residue_word_t compute_residue(input logic [CMD_WIDTH-1:0] cmd,
                                                    input logic [MOD_WIDTH-1:0] a,
                                                    input logic [MOD_WIDTH-1:0] b,
                                                    input logic [EXP_WIDTH-1:0] e);
    residue_word_t        w;
    logic [63:0]          m, sum, base, acc;
    logic [EXP_WIDTH-1:0] p;
    logic [MOD_WIDTH-1:0] inv;
    bit                   ok, uses_b;
    w.result = '0;
    w.error  = ERR_OK;
    m        = shadow_modulus;
    uses_b   = (cmd == CMD_ADD) || (cmd == CMD_SUB) || (cmd == CMD_MUL) || (cmd == CMD_DIV);
    if (cmd > CMD_INV) return w;
    if (m < 2 || a >= m || (uses_b && b >= m)) begin
      w.error = ERR_RANGE;
      return w;
    end
    case (cmd)
      CMD_ADD: begin
        sum = a + b;
        if (sum >= m) sum -= m;
        w.result = sum[MOD_WIDTH-1:0];
      end
      CMD_SUB: begin
        sum = a + (m - b);
        if (sum >= m) sum -= m;
        w.result = sum[MOD_WIDTH-1:0];
      end
      CMD_MUL: w.result = mulmod(a, b, m);
      CMD_DIV: begin
        inv = inverse_of(b, m[MOD_WIDTH-1:0], ok);
        if (ok) w.result = mulmod(a, inv, m);
        else w.error = ERR_NOINV;
      end
      CMD_POW: begin
        acc  = 1 % m;
        base = a;
        p    = e;
        while (p != 0) begin
          if (p[0]) acc = mulmod(acc, base, m);
          base = mulmod(base, base, m);
          p    = p >> 1;
        end
        w.result = acc[MOD_WIDTH-1:0];
      end
      default: begin
        inv = inverse_of(a, m[MOD_WIDTH-1:0], ok);
        if (ok) w.result = inv;
        else w.error = ERR_NOINV;
      end
    endcase
    return w;
  endfunction

  // Sink side: stalls a random number of cycles before each word.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= sink_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    residue_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      sink_stall <= calm ? 0 : $urandom_range(0, 7);
      if (pending_residues.size() == 0) begin
        $error("result word with nothing expected: result=%0d error=%0d",
               out_ch.result, out_ch.error);
        mismatches++;
      end else begin
        want = pending_residues.pop_front();
        words_checked++;
        if (out_ch.result !== want.result) begin
          $error("result: expected %0d, got %0d", want.result, out_ch.result);
          mismatches++;
        end
        if (out_ch.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, out_ch.error);
          mismatches++;
        end
      end
    end
  end

  task automatic send_word(input logic [CMD_WIDTH-1:0] cmd, input logic [MOD_WIDTH-1:0] a,
                           input logic [MOD_WIDTH-1:0] b, input logic [EXP_WIDTH-1:0] e);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.cmd       = cmd;
    in_ch.operand_a = a;
    in_ch.operand_b = b;
    in_ch.exponent  = e;
    do @(posedge clk); while (!in_ch.ready);
    pending_residues.push_back(compute_residue(cmd, a, b, e));
    words_sent++;
    cmd_tally[cmd]++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_residues.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_modulus(input logic [MOD_WIDTH-1:0] m);
    drain();
    cfg_we = 1'b1;
    cfg_wd = m;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_modulus = m;
  endtask

  function automatic logic [MOD_WIDTH-1:0] pick_operand();
    logic [MOD_WIDTH-1:0] m;
    m = shadow_modulus;
    case ($urandom_range(0, 15))
      0: return '0;
      1: return m - 1;
      2: return m;
      3: return MOD_WIDTH'($urandom);
      default: return (m < 2) ? MOD_WIDTH'($urandom) : MOD_WIDTH'($urandom % m);
    endcase
  endfunction

  function automatic logic [EXP_WIDTH-1:0] pick_exponent();
    // Long exponents make pow slow, so most stay short.
    if ($urandom_range(0, 39) == 0) return EXP_WIDTH'({$urandom, $urandom});
    return EXP_WIDTH'($urandom_range(0, 300));
  endfunction

  task automatic send_random_word();
    logic [CMD_WIDTH-1:0] cmd;
    cmd = ($urandom_range(0, 19) == 0) ? CMD_WIDTH'($urandom_range(6, 7))
                                       : CMD_WIDTH'($urandom_range(0, 5));
    send_word(cmd, pick_operand(), pick_operand(), pick_exponent());
  endtask

  task automatic test_reset_modulus();
    logic [MOD_WIDTH-1:0] m;
    m = MOD_RESET;
    send_word(CMD_ADD, m - 1, m - 1, '0);
    send_word(CMD_SUB, '0, m - 1, '0);
    send_word(CMD_MUL, m - 1, m - 1, '0);
    send_word(CMD_DIV, 31'd5, 31'd3, '0);
    send_word(CMD_DIV, 31'd5, '0, '0);
    send_word(CMD_POW, '0, '0, '0);
    send_word(CMD_POW, 31'd2, '0, {EXP_WIDTH{1'b1}});
    send_word(CMD_INV, '0, '0, '0);
    send_word(CMD_INV, m - 1, '0, '0);
    send_word(CMD_ADD, m, '0, '0);
    send_word(CMD_MUL, '0, {MOD_WIDTH{1'b1}}, '0);
    send_word(CMD_POW, 31'd3, {MOD_WIDTH{1'b1}}, 63'd10);
    send_word(3'd6, 31'd1, 31'd1, '0);
    send_word(3'd7, {MOD_WIDTH{1'b1}}, {MOD_WIDTH{1'b1}}, {EXP_WIDTH{1'b1}});
  endtask

  task automatic test_composite_modulus();
    set_modulus(31'd12);
    send_word(CMD_DIV, 31'd7, 31'd4, '0);
    send_word(CMD_INV, 31'd6, '0, '0);
    send_word(CMD_INV, 31'd5, '0, '0);
    send_word(CMD_DIV, 31'd11, 31'd7, '0);
  endtask

  task automatic test_degenerate_modulus();
    set_modulus('0);
    send_word(CMD_ADD, '0, '0, '0);
    send_word(CMD_POW, '0, '0, '0);
    set_modulus(31'd1);
    send_word(CMD_INV, '0, '0, '0);
    set_modulus(31'd2);
    send_word(CMD_POW, 31'd1, '0, '0);
    send_word(CMD_SUB, '0, 31'd1, '0);
  endtask

  task automatic test_max_modulus();
    set_modulus({MOD_WIDTH{1'b1}});
    send_word(CMD_MUL, {{(MOD_WIDTH-1){1'b1}}, 1'b0}, {{(MOD_WIDTH-1){1'b1}}, 1'b0}, '0);
    send_word(CMD_INV, 31'd2, '0, '0);
    send_word(CMD_POW, 31'd7, '0, {EXP_WIDTH{1'b1}});
  endtask

  task automatic test_random_traffic();
    logic [MOD_WIDTH-1:0] m;
    for (int round = 0; round < 6; round++) begin
      case (round % 3)
        0: m = MOD_WIDTH'($urandom_range(2, 60));
        1: m = {MOD_WIDTH{1'b1}};
        default: m = MOD_WIDTH'($urandom) | 31'd2;
      endcase
      set_modulus(m);
      calm = (round == 2);
      for (int i = 0; i < 250; i++) begin
        send_random_word();
        if (i == 125) drain();
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wd          = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    in_ch.exponent  = '0;
    out_ch.ready    = 1'b0;
    sink_stall      = 0;
    calm            = 1'b0;
    mismatches      = 0;
    cycle_count     = 0;
    words_sent      = 0;
    words_checked   = 0;
    shadow_modulus  = MOD_RESET;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_reset_modulus();
    test_composite_modulus();
    test_degenerate_modulus();
    test_max_modulus();
    test_random_traffic();
    drain();

    $display("sent %0d words, checked %0d results in %0d cycles", words_sent,
             words_checked, cycle_count);
    $display("per command: add %0d sub %0d mul %0d div %0d pow %0d inv %0d unknown %0d",
             cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3], cmd_tally[4],
             cmd_tally[5], cmd_tally[6] + cmd_tally[7]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
